>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk_i, off while rst_ni is low.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

>>> sv/rpfsa_pkg.sv
package rpfsa_pkg;

  localparam int unsigned LENGTH_BINS  = 65536;
  localparam int unsigned QUALITY_BINS = 64;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned LEN_W  = 24;
  localparam int unsigned QUAL_W = 6;
  localparam int unsigned IDX_W  = 16;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned TOT_W  = 48;
  localparam int unsigned BIN_W  = 32;

  // bin index widths, and memory address widths with the class bit on top
  localparam int unsigned LB_W  = $clog2(LENGTH_BINS);
  localparam int unsigned QB_W  = $clog2(QUALITY_BINS);
  localparam int unsigned LA_W  = LB_W + 1;
  localparam int unsigned QA_W  = QB_W + 1;
  localparam int unsigned CLR_W = (LA_W > QA_W) ? LA_W : QA_W;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_RECORD   = 2'd0,
    FUNC_LEN_BIN  = 2'd1,
    FUNC_QUAL_BIN = 2'd2
  } func_e;

  // classified item handed from front to back
  typedef struct packed {
    logic              is_record;
    logic              len_rd;     // length bin read-back, index in range
    logic              qual_rd;    // quality bin read-back, index in range
    logic              cls;
    logic [LEN_W-1:0]  read_length;
    logic [QUAL_W-1:0] quality;
    logic [LB_W-1:0]   len_bin;
    logic [QB_W-1:0]   qual_bin;
  } entry_t;

endpackage

>>> sv/rpfsa_if.sv
interface rpfsa_rec_if;
  logic                            valid;
  logic                            ready;
  logic [rpfsa_pkg::FUNC_W-1:0]    func;
  logic                            pass_flag;
  logic [rpfsa_pkg::LEN_W-1:0]     read_length;
  logic [rpfsa_pkg::QUAL_W-1:0]    quality;
  logic [rpfsa_pkg::IDX_W-1:0]     bin_index;

  modport source (output valid, func, pass_flag, read_length, quality, bin_index,
                  input ready);
  modport sink (input valid, func, pass_flag, read_length, quality, bin_index,
                output ready);
endinterface

interface rpfsa_res_if;
  logic                            valid;
  logic                            ready;
  logic [rpfsa_pkg::CNT_W-1:0]     read_count;
  logic [rpfsa_pkg::TOT_W-1:0]     base_total;
  logic [rpfsa_pkg::LEN_W-1:0]     longest_length;
  logic [rpfsa_pkg::QUAL_W-1:0]    min_quality;
  logic                            min_quality_valid;
  logic [rpfsa_pkg::QUAL_W-1:0]    max_quality;
  logic [rpfsa_pkg::BIN_W-1:0]     bin_count;

  modport source (output valid, read_count, base_total, longest_length, min_quality,
                  min_quality_valid, max_quality, bin_count,
                  input ready);
  modport sink (input valid, read_count, base_total, longest_length, min_quality,
                min_quality_valid, max_quality, bin_count,
                output ready);
endinterface

>>> sv/rpfsa_front.sv
module rpfsa_front (
  rpfsa_rec_if.sink           rec_i,
  input  logic                q_full_i,
  input  logic                clearing_i,
  output logic                push_o,
  output rpfsa_pkg::entry_t   entry_o
);

  rpfsa_pkg::func_e func;
  logic             len_long;
  logic             qual_high;

  assign func      = rpfsa_pkg::func_e'(rec_i.func);
  assign len_long  = 32'(rec_i.read_length) >= rpfsa_pkg::LENGTH_BINS;
  assign qual_high = 32'(rec_i.quality) >= rpfsa_pkg::QUALITY_BINS;

  assign rec_i.ready = !q_full_i && !clearing_i;
  assign push_o      = rec_i.valid && rec_i.ready;

  always_comb begin
    entry_o             = '0;
    entry_o.cls         = rec_i.pass_flag;
    entry_o.read_length = rec_i.read_length;
    entry_o.quality     = rec_i.quality;
    case (func)
      rpfsa_pkg::FUNC_RECORD: begin
        entry_o.is_record = 1'b1;
        entry_o.len_bin   = len_long ? rpfsa_pkg::LB_W'(rpfsa_pkg::LENGTH_BINS - 1)
                                     : rpfsa_pkg::LB_W'(rec_i.read_length);
        entry_o.qual_bin  = qual_high ? rpfsa_pkg::QB_W'(rpfsa_pkg::QUALITY_BINS - 1)
                                      : rpfsa_pkg::QB_W'(rec_i.quality);
      end
      rpfsa_pkg::FUNC_LEN_BIN: begin
        entry_o.len_rd  = 32'(rec_i.bin_index) < rpfsa_pkg::LENGTH_BINS;
        entry_o.len_bin = rpfsa_pkg::LB_W'(rec_i.bin_index);
      end
      rpfsa_pkg::FUNC_QUAL_BIN: begin
        entry_o.qual_rd  = 32'(rec_i.bin_index) < rpfsa_pkg::QUALITY_BINS;
        entry_o.qual_bin = rpfsa_pkg::QB_W'(rec_i.bin_index);
      end
      default: begin
      end
    endcase
  end

endmodule

>>> sv/rpfsa_queue.sv
module rpfsa_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rpfsa_pkg::entry_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              head_valid_o,
  output rpfsa_pkg::entry_t head_o
);

  rpfsa_pkg::entry_t                  buf_q [rpfsa_pkg::Q_DEPTH];
  logic [rpfsa_pkg::Q_PTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [rpfsa_pkg::Q_CNT_W-1:0]      cnt_q;

  function automatic logic [rpfsa_pkg::Q_PTR_W-1:0] ptr_inc(
      input logic [rpfsa_pkg::Q_PTR_W-1:0] p);
    return (p == rpfsa_pkg::Q_PTR_W'(rpfsa_pkg::Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head_valid_o = cnt_q != '0;
  assign full_o       = cnt_q == rpfsa_pkg::Q_CNT_W'(rpfsa_pkg::Q_DEPTH);
  assign head_o       = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> sv/rpfsa_back.sv
module rpfsa_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              hd_valid_i,
  input  rpfsa_pkg::entry_t hd_i,
  output logic              pop_o,
  output logic              clearing_o,
  rpfsa_res_if.source       res_o
);

  localparam int unsigned LA_W = rpfsa_pkg::LA_W;
  localparam int unsigned QA_W = rpfsa_pkg::QA_W;

  // histogram memories, class bit on top of the address
  logic [rpfsa_pkg::BIN_W-1:0] len_mem  [2**LA_W];
  logic [rpfsa_pkg::BIN_W-1:0] qual_mem [2**QA_W];

  // clearing pass
  logic                        clearing_q;
  logic [rpfsa_pkg::CLR_W-1:0] clr_cnt_q;

  // execute stage
  logic                        b_valid_q;
  rpfsa_pkg::entry_t           b_q;
  logic [rpfsa_pkg::BIN_W-1:0] len_rd_q, qual_rd_q;
  logic                        len_fwd_q, qual_fwd_q;
  logic [rpfsa_pkg::BIN_W-1:0] len_fwd_data_q, qual_fwd_data_q;

  // per-class statistics
  logic [rpfsa_pkg::CNT_W-1:0]  cnt_q     [2];
  logic [rpfsa_pkg::TOT_W-1:0]  tot_q     [2];
  logic [rpfsa_pkg::LEN_W-1:0]  longest_q [2];
  logic [rpfsa_pkg::QUAL_W-1:0] minq_q    [2];
  logic                         minv_q    [2];
  logic [rpfsa_pkg::QUAL_W-1:0] maxq_q    [2];

  // result register
  logic                         res_valid_q;
  logic [rpfsa_pkg::CNT_W-1:0]  res_cnt_q;
  logic [rpfsa_pkg::TOT_W-1:0]  res_tot_q;
  logic [rpfsa_pkg::LEN_W-1:0]  res_longest_q;
  logic [rpfsa_pkg::QUAL_W-1:0] res_minq_q;
  logic                         res_minv_q;
  logic [rpfsa_pkg::QUAL_W-1:0] res_maxq_q;
  logic [rpfsa_pkg::BIN_W-1:0]  res_bin_q;

  logic                         b_fire;
  logic [LA_W-1:0]              hd_len_addr, b_len_addr;
  logic [QA_W-1:0]              hd_qual_addr, b_qual_addr;
  logic [rpfsa_pkg::BIN_W-1:0]  len_old, qual_old, len_wd, qual_wd;
  logic                         hist_we;
  logic                         c;
  logic [rpfsa_pkg::CNT_W-1:0]  cnt_d;
  logic [rpfsa_pkg::TOT_W-1:0]  tot_d;
  logic [rpfsa_pkg::LEN_W-1:0]  longest_d;
  logic [rpfsa_pkg::QUAL_W-1:0] minq_d, maxq_d;
  logic                         minv_d;
  logic [rpfsa_pkg::BIN_W-1:0]  bin_d;
  logic                         min_upd;

  assign clearing_o = clearing_q;

  assign b_fire = b_valid_q && (!res_valid_q || res_o.ready);
  assign pop_o  = hd_valid_i && (!b_valid_q || b_fire);

  assign hd_len_addr  = {hd_i.cls, hd_i.len_bin};
  assign hd_qual_addr = {hd_i.cls, hd_i.qual_bin};
  assign b_len_addr   = {b_q.cls, b_q.len_bin};
  assign b_qual_addr  = {b_q.cls, b_q.qual_bin};

  // the write that leaves this stage lands on the same edge the next read is taken
  assign len_old  = len_fwd_q ? len_fwd_data_q : len_rd_q;
  assign qual_old = qual_fwd_q ? qual_fwd_data_q : qual_rd_q;
  assign hist_we  = b_fire && b_q.is_record;
  assign len_wd   = len_old + 1'b1;
  assign qual_wd  = qual_old + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clearing_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (&clr_cnt_q) begin
        clearing_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      len_mem[LA_W'(clr_cnt_q)] <= '0;
    end else if (hist_we) begin
      len_mem[b_len_addr] <= len_wd;
    end
    if (pop_o) begin
      len_rd_q <= len_mem[hd_len_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      qual_mem[QA_W'(clr_cnt_q)] <= '0;
    end else if (hist_we) begin
      qual_mem[b_qual_addr] <= qual_wd;
    end
    if (pop_o) begin
      qual_rd_q <= qual_mem[hd_qual_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b_q             <= hd_i;
      len_fwd_q       <= hist_we && (b_len_addr == hd_len_addr);
      qual_fwd_q      <= hist_we && (b_qual_addr == hd_qual_addr);
      len_fwd_data_q  <= len_wd;
      qual_fwd_data_q <= qual_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (pop_o) begin
      b_valid_q <= 1'b1;
    end else if (b_fire) begin
      b_valid_q <= 1'b0;
    end
  end

  always_comb begin
    c         = b_q.cls;
    cnt_d     = cnt_q[c];
    tot_d     = tot_q[c];
    longest_d = longest_q[c];
    minq_d    = minq_q[c];
    minv_d    = minv_q[c];
    maxq_d    = maxq_q[c];
    min_upd   = b_q.is_record && (!minv_q[c] || minq_q[c] > b_q.quality);
    if (b_q.is_record) begin
      cnt_d  = cnt_q[c] + 1'b1;
      tot_d  = tot_q[c] + rpfsa_pkg::TOT_W'(b_q.read_length);
      minv_d = 1'b1;
      if (longest_q[c] < b_q.read_length) begin
        longest_d = b_q.read_length;
      end
      if (maxq_q[c] < b_q.quality) begin
        maxq_d = b_q.quality;
      end
    end
    if (min_upd) begin
      minq_d = b_q.quality;
    end
    if (b_q.len_rd) begin
      bin_d = len_old;
    end else if (b_q.qual_rd) begin
      bin_d = qual_old;
    end else begin
      bin_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        cnt_q[i]     <= '0;
        tot_q[i]     <= '0;
        longest_q[i] <= '0;
        minq_q[i]    <= '0;
        minv_q[i]    <= 1'b0;
        maxq_q[i]    <= '0;
      end
    end else if (hist_we) begin
      cnt_q[c]     <= cnt_d;
      tot_q[c]     <= tot_d;
      longest_q[c] <= longest_d;
      minq_q[c]    <= minq_d;
      minv_q[c]    <= minv_d;
      maxq_q[c]    <= maxq_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (b_fire) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fire) begin
      res_cnt_q     <= cnt_d;
      res_tot_q     <= tot_d;
      res_longest_q <= longest_d;
      res_minq_q    <= minq_d;
      res_minv_q    <= minv_d;
      res_maxq_q    <= maxq_d;
      res_bin_q     <= bin_d;
    end
  end

  assign res_o.valid             = res_valid_q;
  assign res_o.read_count        = res_cnt_q;
  assign res_o.base_total        = res_tot_q;
  assign res_o.longest_length    = res_longest_q;
  assign res_o.min_quality       = res_minq_q;
  assign res_o.min_quality_valid = res_minv_q;
  assign res_o.max_quality       = res_maxq_q;
  assign res_o.bin_count         = res_bin_q;

endmodule

>>> sv/read_pass_fail_stats_accumulator_core.sv
// channel  dir  modport  carries
// rec_i    in   sink     func, pass_flag, read_length, quality, bin_index
// res_o    out  source   read_count, base_total, longest_length, min/max quality, bin_count
//
// One record or read-back per cycle sustained while res_o is ready; the result is registered.
// Histogram read-modify-write: registered read on queue pop, increment with write-back
// forwarding in the execute stage, so back-to-back hits on one bin do not stall.
// After reset a clearing pass zeroes both histogram memories, one address per cycle,
// stepping through 2**CLR_W addresses (131072 by default); rec_i.ready stays low until it ends.
// A stalled res_o holds the result register, then the execute stage, then the
// two-entry queue fills and rec_i.ready drops.
`include "assert_macros.svh"

module read_pass_fail_stats_accumulator_core (
  input logic         clk_i,
  input logic         rst_ni,
  rpfsa_rec_if.sink   rec_i,
  rpfsa_res_if.source res_o
);

  logic              push;
  rpfsa_pkg::entry_t push_entry;
  logic              q_full;
  logic              q_head_valid;
  rpfsa_pkg::entry_t q_head;
  logic              pop;
  logic              clearing;

  rpfsa_front u_front (
    .rec_i      (rec_i),
    .q_full_i   (q_full),
    .clearing_i (clearing),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  rpfsa_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (q_head_valid),
    .head_o       (q_head)
  );

  rpfsa_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .hd_valid_i (q_head_valid),
    .hd_i       (q_head),
    .pop_o      (pop),
    .clearing_o (clearing),
    .res_o      (res_o)
  );

  `ASSERT_NEVER(a_no_result_while_clearing, clearing && res_o.valid, "result during clear")
  `ASSERT_RST(a_transfer_reaches_queue, rec_i.valid && rec_i.ready |=> q_head_valid,
              "accepted item missing from queue")
  `ASSERT_RST(a_empty_class_is_zero,
              res_o.valid && !res_o.min_quality_valid |->
                res_o.max_quality == '0 && res_o.longest_length == '0 &&
                res_o.base_total == '0,
              "class without reads has nonzero stats")

endmodule
